/* hw/rtl/kos_pkg.sv */
// Shared types, constants and compare function for the k-th order statistic selector.
package kos_pkg;

    localparam int DATA_W         = 32;
    localparam int RANK_W         = 9;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 9;
    localparam int HEAP_DEPTH_DEF = 256;

    localparam logic [CFG_IDX_W-1:0] REG_RANK_K         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SELECT_LARGEST = 2'd1;

    typedef struct packed {
        logic signed [DATA_W-1:0] kth_value;
        logic                     short_set;
    } kos_result_t;

    // true if a belongs above b in the heap
    function automatic logic sits_above(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b,
        input logic                     largest
    );
        sits_above = largest ? (a < b) : (a > b);
    endfunction

endpackage

/* hw/rtl/kos_heap_ram.sv */
// Heap store: one write port, one read port, registered read data.
module kos_heap_ram #(
    parameter int DEPTH = kos_pkg::HEAP_DEPTH_DEF,
    parameter int AW    = 8
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [AW-1:0]                     waddr,
    input  logic signed [kos_pkg::DATA_W-1:0] wdata,
    input  logic [AW-1:0]                     raddr,
    output logic signed [kos_pkg::DATA_W-1:0] rdata
);
    import kos_pkg::*;

    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/kos_sift_ctrl.sv */
// Heap sequencer: push with sift-up, replace-top with sift-down, fill count and top copy.
module kos_sift_ctrl #(
    parameter int HEAP_DEPTH = kos_pkg::HEAP_DEPTH_DEF,
    parameter int AW         = 8,
    parameter int FW         = 9
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic signed [kos_pkg::DATA_W-1:0] sample_value,
    input  logic                              last_of_set,
    input  logic [FW-1:0]                     k_eff,
    input  logic                              select_largest,
    input  logic                              cfg_clear,
    output logic                              res_valid,
    input  logic                              res_ready,
    output kos_pkg::kos_result_t              result
);
    import kos_pkg::*;

    localparam int IW = AW + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_DN_R,
        ST_DN_C,
        ST_PUT,
        ST_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [FW-1:0]            fill_reg, fill_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic                     last_reg, last_next;
    logic [AW-1:0]            pos_reg, pos_next;
    logic signed [DATA_W-1:0] lval_reg, lval_next;
    logic                     rok_reg, rok_next;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic signed [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic signed [DATA_W-1:0] ram_rdata;

    logic [IW-1:0]            fill_ext;
    logic [AW-1:0]            up_parent;
    logic [IW-1:0]            l_idx;
    logic [IW-1:0]            r_idx;
    logic                     pick_r;
    logic signed [DATA_W-1:0] child_val;
    logic [IW-1:0]            child_idx;
    logic [IW-1:0]            next_l;

    kos_heap_ram #(
        .DEPTH (HEAP_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign fill_ext  = IW'(fill_reg);
    assign up_parent = AW'((pos_reg - 1'b1) >> 1);
    assign l_idx     = {1'b0, pos_reg, 1'b1};
    assign r_idx     = l_idx + 1'b1;
    assign pick_r    = rok_reg && sits_above(ram_rdata, lval_reg, select_largest);
    assign child_val = pick_r ? ram_rdata : lval_reg;
    assign child_idx = pick_r ? r_idx : l_idx;
    assign next_l    = {1'b0, child_idx[AW-1:0], 1'b1};

    assign item_ready       = (state_reg == ST_IDLE);
    assign res_valid        = (state_reg == ST_DONE) && last_reg;
    assign result.kth_value = top_reg;
    assign result.short_set = (fill_reg < k_eff);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        top_next   = top_reg;
        val_next   = val_reg;
        last_next  = last_reg;
        pos_next   = pos_reg;
        lval_next  = lval_reg;
        rok_next   = rok_reg;
        ram_we     = 1'b0;
        ram_waddr  = pos_reg;
        ram_wdata  = val_reg;
        ram_raddr  = up_parent;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    val_next  = sample_value;
                    last_next = last_of_set;
                    pos_next  = '0;
                    if (fill_reg < k_eff)
                    begin
                        fill_next = FW'(fill_reg + 1'b1);
                        if (fill_reg == '0)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = '0;
                            ram_wdata  = sample_value;
                            top_next   = sample_value;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            pos_next   = AW'(fill_reg);
                            ram_raddr  = AW'((fill_reg - 1'b1) >> 1);
                            state_next = ST_UP;
                        end
                    end
                    else if (sits_above(top_reg, sample_value, select_largest))
                    begin
                        if (fill_reg == FW'(1))
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = '0;
                            ram_wdata  = sample_value;
                            top_next   = sample_value;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            ram_raddr  = AW'(1);
                            state_next = ST_DN_R;
                        end
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (cfg_clear)
                begin
                    fill_next = '0;
                end
            end

            ST_UP:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                if (sits_above(val_reg, ram_rdata, select_largest))
                begin
                    ram_wdata = ram_rdata;
                    pos_next  = up_parent;
                    if (up_parent == '0)
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        ram_raddr = AW'((up_parent - 1'b1) >> 1);
                    end
                end
                else
                begin
                    ram_wdata  = val_reg;
                    state_next = ST_DONE;
                end
            end

            ST_DN_R:
            begin
                lval_next  = ram_rdata;
                rok_next   = (r_idx < fill_ext);
                ram_raddr  = r_idx[AW-1:0];
                state_next = ST_DN_C;
            end

            ST_DN_C:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                if (sits_above(child_val, val_reg, select_largest))
                begin
                    ram_wdata = child_val;
                    if (pos_reg == '0)
                    begin
                        top_next = child_val;
                    end
                    pos_next = child_idx[AW-1:0];
                    if (next_l < fill_ext)
                    begin
                        ram_raddr  = next_l[AW-1:0];
                        state_next = ST_DN_R;
                    end
                    else
                    begin
                        state_next = ST_PUT;
                    end
                end
                else
                begin
                    ram_wdata = val_reg;
                    if (pos_reg == '0)
                    begin
                        top_next = val_reg;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_PUT:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = val_reg;
                if (pos_reg == '0)
                begin
                    top_next = val_reg;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (res_ready)
                begin
                    fill_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            last_reg  <= 1'b0;
            rok_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            last_reg  <= last_next;
            rok_reg   <= rok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        val_reg  <= val_next;
        pos_reg  <= pos_next;
        lval_reg <= lval_next;
    end

endmodule

/* hw/rtl/kth_order_statistic_select_unit.sv */
// K-th smallest/largest selector over a bounded binary heap held in one memory.
// A push climbs one tree level per ST_UP step (sift-up), ending in ST_PUT or ST_DONE.
// A replace-top descends one level per ST_DN_R/ST_DN_C pair (sift-down), the pair set by
// the single read port fetching both children; a non-replacing word goes straight to ST_DONE.
// One word at a time; a finished result waits in the output register while the next is taken.
// Reset clears control, fill count and config registers (k = 1, smallest mode); heap store is not cleared.
module kth_order_statistic_select_unit #(
    parameter int HEAP_DEPTH = kos_pkg::HEAP_DEPTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [kos_pkg::DATA_W-1:0]    sample_value,
    input  logic                                 last_of_set,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [kos_pkg::DATA_W-1:0]    kth_value,
    output logic                                 short_set,
    input  logic                                 cfg_write_en,
    input  logic [kos_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [kos_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import kos_pkg::*;

    localparam int AW    = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int FW    = $clog2(HEAP_DEPTH + 1);
    localparam int CMP_W = (FW > RANK_W) ? FW : RANK_W;

    logic [RANK_W-1:0]        rank_k_reg;
    logic                     select_largest_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] kth_value_reg;
    logic                     short_set_reg;

    logic [FW-1:0]            k_eff;
    logic [CMP_W-1:0]         rank_ext;
    logic                     cfg_clear;
    logic                     res_valid;
    logic                     res_ready;
    kos_result_t              result;

    assign rank_ext = CMP_W'(rank_k_reg);

    always_comb
    begin
        if (rank_k_reg == '0)
        begin
            k_eff = FW'(1);
        end
        else if (rank_ext > CMP_W'(HEAP_DEPTH))
        begin
            k_eff = FW'(HEAP_DEPTH);
        end
        else
        begin
            k_eff = FW'(rank_ext);
        end
    end

    assign cfg_clear = cfg_write_en &&
                       ((cfg_index == REG_RANK_K) || (cfg_index == REG_SELECT_LARGEST));
    assign res_ready = !out_valid_reg || out_ready;

    kos_sift_ctrl #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .AW         (AW),
        .FW         (FW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (in_valid),
        .item_ready     (in_ready),
        .sample_value   (sample_value),
        .last_of_set    (last_of_set),
        .k_eff          (k_eff),
        .select_largest (select_largest_reg),
        .cfg_clear      (cfg_clear),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_k_reg         <= RANK_W'(1);
            select_largest_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_RANK_K:         rank_k_reg         <= cfg_wdata[RANK_W-1:0];
                REG_SELECT_LARGEST: select_largest_reg <= cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            kth_value_reg <= result.kth_value;
            short_set_reg <= result.short_set;
        end
    end

    assign out_valid = out_valid_reg;
    assign kth_value = kth_value_reg;
    assign short_set = short_set_reg;

endmodule
